// ----- rtl/core/ps2dec_pkg.sv -----
// Shared types, scan code constants and key maps for the PS/2 set 2 decoder.
`default_nettype none

package ps2dec_pkg;

	// Number of key map entries that the lookup may address.
	localparam int MAP_ENTRIES = 136;
	// Entries of the key maps that hold characters.
	localparam int ROM_FILLED = 132;

	localparam logic [7:0] CODE_NONE    = 8'h00;
	localparam logic [7:0] CODE_BREAK   = 8'hF0;
	localparam logic [7:0] CODE_EXT     = 8'hE0;
	localparam logic [7:0] CODE_LSHIFT  = 8'h12;
	localparam logic [7:0] CODE_RSHIFT  = 8'h59;
	localparam logic [7:0] CODE_CTRL    = 8'h14;
	localparam logic [7:0] CODE_ALTGR   = 8'h11;

	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;

	// Bit 0 is the break prefix, bit 5 is Ctrl.
	typedef struct packed {
		logic ctrl;
		logic altgr;
		logic shr;
		logic shl;
		logic ext;
		logic brk;
	} key_flags_t;

	localparam logic [7:0] ROM_PLAIN [0:ROM_FILLED-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h60, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
		8'h00, 8'h00, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
		8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
		8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
		8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
		8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
		8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
		8'h00, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'h00,
		8'h00, 8'h00, 8'h27, 8'h00, 8'h5B, 8'h3D, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h0D, 8'h5D, 8'h00, 8'h5C, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h00,
		8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
		8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
		8'h00, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] ROM_SHIFT [0:ROM_FILLED-1] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h7E, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
		8'h00, 8'h00, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h40, 8'h00,
		8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h00,
		8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
		8'h00, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'h00,
		8'h00, 8'h00, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'h00,
		8'h00, 8'h3C, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'h00,
		8'h00, 8'h3E, 8'h3F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'h00,
		8'h00, 8'h00, 8'h22, 8'h00, 8'h7B, 8'h2B, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h0D, 8'h7D, 8'h00, 8'h7C, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h00,
		8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
		8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
		8'h00, 8'h2B, 8'h33, 8'h2D, 8'h2A, 8'h39, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00
	};

endpackage

`default_nettype wire

// ----- rtl/core/ps2dec_decode.sv -----
// Combinational decode of one scan code against the current key flags.
`default_nettype none

module ps2dec_decode (
	input  wire logic [7:0]               code,
	input  wire ps2dec_pkg::key_flags_t   flags,
	output      ps2dec_pkg::key_flags_t   flags_next,
	output      logic [7:0]               char_code
);

	logic [7:0] ext_char;
	logic [7:0] rom_char;
	logic [7:0] raw_char;
	logic       in_rom;

	// Navigation keys, keypad slash and keypad enter behind the extended prefix.
	always_comb begin
		unique case (code)
			8'h7D:   ext_char = 8'd25;
			8'h71:   ext_char = 8'd127;
			8'h7A:   ext_char = 8'd26;
			8'h75:   ext_char = 8'd11;
			8'h6B:   ext_char = 8'd8;
			8'h72:   ext_char = 8'd12;
			8'h74:   ext_char = 8'd21;
			8'h4A:   ext_char = 8'h2F;
			8'h5A:   ext_char = 8'd13;
			default: ext_char = 8'd0;
		endcase
	end

	assign in_rom = ({1'b0, code} < 9'(ps2dec_pkg::MAP_ENTRIES)) &&
			({1'b0, code} < 9'(ps2dec_pkg::ROM_FILLED));

	always_comb begin
		rom_char = 8'd0;
		if (in_rom) begin
			if (flags.shl || flags.shr)
				rom_char = ps2dec_pkg::ROM_SHIFT[code];
			else
				rom_char = ps2dec_pkg::ROM_PLAIN[code];
		end
	end

	assign raw_char = flags.ext ? ext_char : rom_char;

	always_comb begin
		flags_next = flags;
		char_code  = 8'd0;
		if (code == ps2dec_pkg::CODE_NONE) begin
			flags_next = flags;
		end else if (code == ps2dec_pkg::CODE_BREAK) begin
			flags_next.brk = 1'b1;
		end else if (code == ps2dec_pkg::CODE_EXT) begin
			flags_next.ext = 1'b1;
		end else if (flags.brk) begin
			if (code == ps2dec_pkg::CODE_LSHIFT)
				flags_next.shl = 1'b0;
			else if (code == ps2dec_pkg::CODE_RSHIFT)
				flags_next.shr = 1'b0;
			else if (code == ps2dec_pkg::CODE_CTRL)
				flags_next.ctrl = 1'b0;
			else if (code == ps2dec_pkg::CODE_ALTGR && flags.ext)
				flags_next.altgr = 1'b0;
			flags_next.brk = 1'b0;
			flags_next.ext = 1'b0;
		end else if (code == ps2dec_pkg::CODE_LSHIFT) begin
			flags_next.shl = 1'b1;
		end else if (code == ps2dec_pkg::CODE_RSHIFT) begin
			flags_next.shr = 1'b1;
		end else if (code == ps2dec_pkg::CODE_CTRL) begin
			flags_next.ctrl = 1'b1;
		end else begin
			if (code == ps2dec_pkg::CODE_ALTGR && flags.ext)
				flags_next.altgr = 1'b1;
			char_code = raw_char;
			// Ctrl folds letters onto 1..26 and turns carriage return into linefeed.
			if (flags.ctrl) begin
				if (raw_char >= 8'h41 && raw_char <= 8'h5A)
					char_code = raw_char - 8'h40;
				else if (raw_char >= 8'h61 && raw_char <= 8'h7A)
					char_code = raw_char - 8'h60;
				else if (raw_char == ps2dec_pkg::CHAR_CR)
					char_code = ps2dec_pkg::CHAR_LF;
			end
			flags_next.brk = 1'b0;
			flags_next.ext = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ps2_scancode_to_char_decoder.sv -----
// Top level of the PS/2 set 2 scan code to character byte decoder.
//
//   channel   direction  handshake                payload
//   code      in         code_valid / code_ready  scan_code[7:0]
//   char      out        char_valid / char_ready  out_byte[7:0], last
//
// A scan code is registered on transfer and decoded from that register; as it
// advances, the key flags are updated and the character moves into the output
// register. One scan code is taken every cycle unless the output side stalls;
// a character of 128 or more leaves as two UTF-8 bytes, holding the decode stage.
// Reset clears the key flags and both stage valid bits.
// Codes that give no character never wait for the output side.
`default_nettype none

module ps2_scancode_to_char_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       code_valid,
	output      logic       code_ready,
	input  wire logic [7:0] scan_code,
	output      logic       char_valid,
	input  wire logic       char_ready,
	output      logic [7:0] out_byte,
	output      logic       last
);

	logic                   valid_s1;
	logic [7:0]             code_s1;
	ps2dec_pkg::key_flags_t flags_q;
	ps2dec_pkg::key_flags_t flags_next;
	logic [7:0]             char_code;

	logic                   valid_s2;
	logic [7:0]             char_s2;
	logic                   lead_sent_q;

	logic                   wide;
	logic                   out_done;
	logic                   s2_free;
	logic                   adv_s1;

	ps2dec_decode u_decode (
		.code       (code_s1),
		.flags      (flags_q),
		.flags_next (flags_next),
		.char_code  (char_code)
	);

	assign wide     = char_s2[7];
	assign last     = !wide || lead_sent_q;
	assign out_byte = (wide && !lead_sent_q) ? {6'b110000, char_s2[7:6]}
		: (wide ? {2'b10, char_s2[5:0]} : char_s2);
	assign char_valid = valid_s2;

	assign out_done   = valid_s2 && char_ready && last;
	assign s2_free    = !valid_s2 || out_done;
	assign adv_s1     = valid_s1 && ((char_code == 8'd0) || s2_free);
	assign code_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (code_valid && code_ready)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && code_ready)
			code_s1 <= scan_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			lead_sent_q <= 1'b0;
		end else begin
			if (adv_s1 && char_code != 8'd0) begin
				valid_s2    <= 1'b1;
				lead_sent_q <= 1'b0;
			end else if (out_done) begin
				valid_s2    <= 1'b0;
				lead_sent_q <= 1'b0;
			end else if (valid_s2 && char_ready) begin
				// Lead byte of a two-byte sequence has been transferred.
				lead_sent_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && char_code != 8'd0)
			char_s2 <= char_code;
	end

	a_trail_follows: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && !last |=> char_valid && last)
		else $error("trail byte did not follow the lead byte");

	a_lead_form: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !last |-> out_byte[7:5] == 3'b110)
		else $error("lead byte has the wrong form");

	a_break_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && flags_q.brk && code_s1 != ps2dec_pkg::CODE_NONE &&
		code_s1 != ps2dec_pkg::CODE_BREAK && code_s1 != ps2dec_pkg::CODE_EXT
		|=> !flags_q.brk && !flags_q.ext)
		else $error("break prefix not cleared after a break code");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> code_ready)
		else $error("decode stage empty but no transfer allowed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_done |-> !(adv_s1 && char_code != 8'd0))
		else $error("output register overwritten before transfer");

endmodule

`default_nettype wire
